@@ hdl/kcl_pkg.sv @@
`default_nettype none

package kcl_pkg;

    localparam int KCL_CODE_DIGITS = 4;

    // request types
    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    // raw keypad codes
    localparam logic [7:0] KEY_DIGIT_MAX = 8'd9;
    localparam logic [7:0] KEY_PLUS      = 8'd43;
    localparam logic [7:0] KEY_MINUS     = 8'd45;

    // commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_ALARM = 2'd2;
    localparam logic [1:0] CMD_SAVE  = 2'd3;

    // status codes
    localparam logic [3:0] STS_PROMPT   = 4'd0;
    localparam logic [3:0] STS_DIGIT    = 4'd1;
    localparam logic [3:0] STS_WRONG    = 4'd2;
    localparam logic [3:0] STS_MENU     = 4'd3;
    localparam logic [3:0] STS_OPEN     = 4'd4;
    localparam logic [3:0] STS_ALARM    = 4'd5;
    localparam logic [3:0] STS_NEW      = 4'd6;
    localparam logic [3:0] STS_AGAIN    = 4'd7;
    localparam logic [3:0] STS_CHANGED  = 4'd8;
    localparam logic [3:0] STS_MISMATCH = 4'd9;
    localparam logic [3:0] STS_IGNORED  = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_WRONG_TRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DOOR_OPEN_TICKS = 2'd1;
    localparam logic [1:0] CFG_ALARM_TICKS     = 2'd2;

    // reset values
    localparam logic [2:0]  WRONG_TRY_LIMIT_RST = 3'd3;
    localparam logic [15:0] DOOR_OPEN_TICKS_RST = 16'd32226;
    localparam logic [15:0] ALARM_TICKS_RST     = 16'd58594;
    localparam logic [15:0] STORED_CODE_RST     = 16'h1111;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  key_value;
        logic [15:0] load_code;
    } kcl_item_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] saved_code;
        logic [3:0]  status;
    } kcl_result_t;

    typedef struct packed {
        logic [2:0]  wrong_try_limit;
        logic [15:0] door_open_ticks;
        logic [15:0] alarm_ticks;
    } kcl_cfg_t;

endpackage

`default_nettype wire

@@ hdl/kcl_if.sv @@
`default_nettype none

interface kcl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  key_value;
    logic [15:0] load_code;

    modport source (output valid, output req_type, output key_value, output load_code,
                    input ready);
    modport sink (input valid, input req_type, input key_value, input load_code,
                  output ready);
endinterface

interface kcl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] saved_code;
    logic [3:0]  status;

    modport source (output valid, output command, output saved_code, output status,
                    input ready);
    modport sink (input valid, input command, input saved_code, input status,
                  output ready);
endinterface

interface kcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/kcl_core.sv @@
`default_nettype none

module kcl_core #(
    parameter int CODE_DIGITS = kcl_pkg::KCL_CODE_DIGITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  kcl_pkg::kcl_item_t  item,
    input  kcl_pkg::kcl_cfg_t   cfg,
    output kcl_pkg::kcl_result_t result
);

    import kcl_pkg::*;

    localparam int DCW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [DCW-1:0] DIGIT_LAST = DCW'(CODE_DIGITS - 1);

    typedef enum logic [2:0] {
        MODE_ENTRY,
        MODE_MENU,
        MODE_OPEN,
        MODE_ALARM,
        MODE_NEW1,
        MODE_NEW2
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [DCW-1:0] digit_count_reg, digit_count_next;
    logic [15:0]    entered_code_reg, entered_code_next;
    logic [15:0]    stored_code_reg, stored_code_next;
    logic [15:0]    first_new_code_reg, first_new_code_next;
    logic [2:0]     wrong_count_reg, wrong_count_next;
    logic [15:0]    wait_counter_reg, wait_counter_next;

    logic           is_digit;
    logic           code_done;
    logic [15:0]    shifted;
    logic [15:0]    wait_inc;
    logic [15:0]    wait_limit;
    logic [3:0]     wrong_inc;
    logic [DCW-1:0] count_step;

    always_comb
    begin
        is_digit   = item.key_value <= KEY_DIGIT_MAX;
        code_done  = digit_count_reg == DIGIT_LAST;
        shifted    = {entered_code_reg[11:0], item.key_value[3:0]};
        wait_inc   = wait_counter_reg + 16'd1;
        wait_limit = (mode_reg == MODE_OPEN) ? cfg.door_open_ticks : cfg.alarm_ticks;
        wrong_inc  = {1'b0, wrong_count_reg} + 4'd1;
        count_step = code_done ? '0 : digit_count_reg + DCW'(1);

        mode_next           = mode_reg;
        digit_count_next    = digit_count_reg;
        entered_code_next   = entered_code_reg;
        stored_code_next    = stored_code_reg;
        first_new_code_next = first_new_code_reg;
        wrong_count_next    = wrong_count_reg;
        wait_counter_next   = wait_counter_reg;

        result.command    = CMD_NONE;
        result.saved_code = 16'd0;
        result.status     = STS_IGNORED;

        case (item.req_type)
            REQ_LOAD:
            begin
                stored_code_next = item.load_code;
                result.status    = STS_PROMPT;
            end
            REQ_TICK:
            begin
                if (mode_reg == MODE_OPEN || mode_reg == MODE_ALARM)
                begin
                    wait_counter_next = wait_inc;
                    if (wait_inc >= wait_limit)
                    begin
                        mode_next         = MODE_ENTRY;
                        wait_counter_next = 16'd0;
                        digit_count_next  = '0;
                        entered_code_next = 16'd0;
                        result.status     = STS_PROMPT;
                    end
                    else
                    begin
                        result.status = (mode_reg == MODE_OPEN) ? STS_OPEN : STS_ALARM;
                    end
                end
            end
            REQ_KEY:
            begin
                unique case (mode_reg)
                    MODE_MENU:
                    begin
                        if (item.key_value == KEY_PLUS)
                        begin
                            mode_next         = MODE_OPEN;
                            wait_counter_next = 16'd0;
                            result.command    = CMD_OPEN;
                            result.status     = STS_OPEN;
                        end
                        else if (item.key_value == KEY_MINUS)
                        begin
                            mode_next         = MODE_NEW1;
                            digit_count_next  = '0;
                            entered_code_next = 16'd0;
                            result.status     = STS_NEW;
                        end
                    end
                    MODE_ENTRY:
                    begin
                        if (is_digit)
                        begin
                            result.status     = STS_DIGIT;
                            entered_code_next = shifted;
                            digit_count_next  = count_step;
                            if (code_done)
                            begin
                                entered_code_next = 16'd0;
                                if (shifted == stored_code_reg)
                                begin
                                    mode_next        = MODE_MENU;
                                    wrong_count_next = 3'd0;
                                    result.status    = STS_MENU;
                                end
                                else if (wrong_inc >= {1'b0, cfg.wrong_try_limit})
                                begin
                                    mode_next         = MODE_ALARM;
                                    wrong_count_next  = 3'd0;
                                    wait_counter_next = 16'd0;
                                    result.command    = CMD_ALARM;
                                    result.status     = STS_ALARM;
                                end
                                else
                                begin
                                    wrong_count_next = wrong_inc[2:0];
                                    result.status    = STS_WRONG;
                                end
                            end
                        end
                    end
                    MODE_NEW1:
                    begin
                        if (is_digit)
                        begin
                            result.status     = STS_DIGIT;
                            entered_code_next = shifted;
                            digit_count_next  = count_step;
                            if (code_done)
                            begin
                                first_new_code_next = shifted;
                                mode_next           = MODE_NEW2;
                                entered_code_next   = 16'd0;
                                result.status       = STS_AGAIN;
                            end
                        end
                    end
                    MODE_NEW2:
                    begin
                        if (is_digit)
                        begin
                            result.status     = STS_DIGIT;
                            entered_code_next = shifted;
                            digit_count_next  = count_step;
                            if (code_done)
                            begin
                                if (shifted == first_new_code_reg)
                                begin
                                    stored_code_next  = shifted;
                                    result.command    = CMD_SAVE;
                                    result.saved_code = shifted;
                                    result.status     = STS_CHANGED;
                                end
                                else
                                begin
                                    result.status = STS_MISMATCH;
                                end
                                mode_next         = MODE_ENTRY;
                                entered_code_next = 16'd0;
                            end
                        end
                    end
                    default:
                    begin
                        // door open or alarm: keys are ignored
                    end
                endcase
            end
            default:
            begin
                // unknown request type, ignored
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_ENTRY;
            digit_count_reg    <= '0;
            entered_code_reg   <= 16'd0;
            stored_code_reg    <= STORED_CODE_RST;
            first_new_code_reg <= 16'd0;
            wrong_count_reg    <= 3'd0;
            wait_counter_reg   <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg           <= mode_next;
            digit_count_reg    <= digit_count_next;
            entered_code_reg   <= entered_code_next;
            stored_code_reg    <= stored_code_next;
            first_new_code_reg <= first_new_code_next;
            wrong_count_reg    <= wrong_count_next;
            wait_counter_reg   <= wait_counter_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/keypad_code_lock_controller.sv @@
// channel  | direction | payload                              | transaction when
// ---------+-----------+--------------------------------------+-------------------
// item     | in        | req_type, key_value, load_code       | valid && ready
// result   | out       | command, saved_code, status          | valid && ready
// cfg      | in        | index, data                          | valid && ready
//
// one item per cycle while results are taken; each item gives exactly one result
// an accepted item is captured in the input register, and its result is registered into
// the output register when the input stage advances
// reset clears both stages, loads the default limits and sets the stored code to 1111
// a stalled result holds the output register; the input stage fills behind it and
// item.ready drops only when both stages are full; cfg.ready is always high

`default_nettype none

module keypad_code_lock_controller #(
    parameter int CODE_DIGITS = kcl_pkg::KCL_CODE_DIGITS
) (
    input  logic                clk,
    input  logic                rst_n,
    kcl_item_if.sink            item,
    kcl_result_if.source        result,
    kcl_cfg_if.sink             cfg
);

    import kcl_pkg::*;

    logic        in_valid_reg;
    kcl_item_t   in_item_reg;
    logic        out_valid_reg;
    kcl_result_t out_result_reg;
    kcl_cfg_t    cfg_reg;
    kcl_result_t core_result;
    logic        advance;
    logic        item_take;

    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item_take = item.valid && item.ready;

    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.command    = out_result_reg.command;
    assign result.saved_code = out_result_reg.saved_code;
    assign result.status     = out_result_reg.status;

    kcl_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_item_reg.req_type  <= item.req_type;
            in_item_reg.key_value <= item.key_value;
            in_item_reg.load_code <= item.load_code;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    // register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrong_try_limit <= WRONG_TRY_LIMIT_RST;
            cfg_reg.door_open_ticks <= DOOR_OPEN_TICKS_RST;
            cfg_reg.alarm_ticks     <= ALARM_TICKS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WRONG_TRY_LIMIT: cfg_reg.wrong_try_limit <= cfg.data[2:0];
                CFG_DOOR_OPEN_TICKS: cfg_reg.door_open_ticks <= cfg.data;
                CFG_ALARM_TICKS:     cfg_reg.alarm_ticks     <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
